// ===== rtl/abs_pkg.sv =====
package abs_pkg;

   localparam int COORD_W = 32;
   localparam int MUL_W = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SQ_SUM_W = 66;
   localparam int SQRT_ITERS = PROD_W / 2;
   localparam int DIV_ITERS = PROD_W;
   localparam int ITER_W = $clog2(DIV_ITERS + 1);

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FEW = 2'd1;
   localparam logic [1:0] STATUS_OVF = 2'd2;

   typedef logic [2:0][COORD_W-1:0] vec3_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic                      last_point;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-1:0]        sphere_radius;
      logic [1:0]                status;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECIDE, ST_ERROR, ST_P1_RD, ST_P1_UPD, ST_SPAN_SQ, ST_SPAN_ACC,
      ST_SPAN_CMP, ST_INIT_CTR, ST_INIT_SQRT, ST_INIT_RAD, ST_P2_RD, ST_P2_SQ,
      ST_P2_ACC, ST_P2_LIM, ST_P2_TEST, ST_P2_SQRT, ST_P2_RAD, ST_P2_SHIFT,
      ST_P2_MUL, ST_P2_DLD, ST_P2_DIV, ST_P2_UPD, ST_P2_NEXT, ST_RESULT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_START, OP_ERROR, OP_READ, OP_P1_UPD, OP_SPAN_SQ,
      OP_ACC, OP_SPAN_CMP, OP_INIT_CTR, OP_SQRT_STEP, OP_INIT_RAD, OP_P2_SQ,
      OP_P2_LIM, OP_P2_TEST, OP_P2_RAD, OP_P2_SHIFT, OP_P2_MUL, OP_DIV_LOAD,
      OP_DIV_STEP, OP_P2_UPD, OP_NEXT, OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic err_ovf;
      logic err_few;
      logic idx_last;
      logic k_last;
      logic pair_last;
      logic sqrt_last;
      logic div_last;
      logic outside;
   } dp_status_type;

endpackage

// ===== rtl/abs_ctrl.sv =====
module abs_ctrl
   import abs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            last_point,
   input  dp_status_type   dp_status,
   output dp_cmd_type      dp_cmd,
   output logic            busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd.op = OP_NONE;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               dp_cmd.op = OP_LOAD;
               if (last_point) state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            dp_cmd.op = OP_START;
            if (dp_status.err_ovf || dp_status.err_few) state_in = ST_ERROR;
            else state_in = ST_P1_RD;
         end
         ST_ERROR: begin
            dp_cmd.op = OP_ERROR;
            state_in = ST_IDLE;
         end
         ST_P1_RD: begin
            dp_cmd.op = OP_READ;
            state_in = ST_P1_UPD;
         end
         ST_P1_UPD: begin
            dp_cmd.op = OP_P1_UPD;
            state_in = dp_status.idx_last ? ST_SPAN_SQ : ST_P1_RD;
         end
         ST_SPAN_SQ: begin
            dp_cmd.op = OP_SPAN_SQ;
            state_in = ST_SPAN_ACC;
         end
         ST_SPAN_ACC: begin
            dp_cmd.op = OP_ACC;
            state_in = dp_status.k_last ? ST_SPAN_CMP : ST_SPAN_SQ;
         end
         ST_SPAN_CMP: begin
            dp_cmd.op = OP_SPAN_CMP;
            state_in = dp_status.pair_last ? ST_INIT_CTR : ST_SPAN_SQ;
         end
         ST_INIT_CTR: begin
            dp_cmd.op = OP_INIT_CTR;
            state_in = ST_INIT_SQRT;
         end
         ST_INIT_SQRT: begin
            dp_cmd.op = OP_SQRT_STEP;
            if (dp_status.sqrt_last) state_in = ST_INIT_RAD;
         end
         ST_INIT_RAD: begin
            dp_cmd.op = OP_INIT_RAD;
            state_in = ST_P2_RD;
         end
         ST_P2_RD: begin
            dp_cmd.op = OP_READ;
            state_in = ST_P2_SQ;
         end
         ST_P2_SQ: begin
            dp_cmd.op = OP_P2_SQ;
            state_in = ST_P2_ACC;
         end
         ST_P2_ACC: begin
            dp_cmd.op = OP_ACC;
            state_in = dp_status.k_last ? ST_P2_LIM : ST_P2_SQ;
         end
         ST_P2_LIM: begin
            dp_cmd.op = OP_P2_LIM;
            state_in = ST_P2_TEST;
         end
         ST_P2_TEST: begin
            dp_cmd.op = OP_P2_TEST;
            if (dp_status.outside) state_in = ST_P2_SQRT;
            else if (dp_status.idx_last) state_in = ST_RESULT;
            else state_in = ST_P2_NEXT;
         end
         ST_P2_SQRT: begin
            dp_cmd.op = OP_SQRT_STEP;
            if (dp_status.sqrt_last) state_in = ST_P2_RAD;
         end
         ST_P2_RAD: begin
            dp_cmd.op = OP_P2_RAD;
            state_in = ST_P2_SHIFT;
         end
         ST_P2_SHIFT: begin
            dp_cmd.op = OP_P2_SHIFT;
            state_in = ST_P2_MUL;
         end
         ST_P2_MUL: begin
            dp_cmd.op = OP_P2_MUL;
            state_in = ST_P2_DLD;
         end
         ST_P2_DLD: begin
            dp_cmd.op = OP_DIV_LOAD;
            state_in = ST_P2_DIV;
         end
         ST_P2_DIV: begin
            dp_cmd.op = OP_DIV_STEP;
            if (dp_status.div_last) state_in = ST_P2_UPD;
         end
         ST_P2_UPD: begin
            dp_cmd.op = OP_P2_UPD;
            if (!dp_status.k_last) state_in = ST_P2_MUL;
            else if (dp_status.idx_last) state_in = ST_RESULT;
            else state_in = ST_P2_NEXT;
         end
         ST_P2_NEXT: begin
            dp_cmd.op = OP_NEXT;
            state_in = ST_P2_RD;
         end
         ST_RESULT: begin
            dp_cmd.op = OP_RESULT;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/abs_datapath.sv =====
module abs_datapath
   import abs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
)
(
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      dp_cmd,
   input  req_payload_type req_payload,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data,
   output dp_status_type   dp_status,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   vec3_type              store_mem [MAX_POINTS];
   vec3_type              rd_data_ff;
   logic [CW-1:0]         count_ff;
   logic                  ovf_ff;
   logic [AW-1:0]         idx_ff;
   logic [1:0]            k_ff;
   logic [1:0]            pair_ff;
   logic [1:0]            best_pair_ff;
   logic [SQ_SUM_W-1:0]   acc_ff;
   logic [SQ_SUM_W-1:0]   best_ff;
   vec3_type              ext_ff [6];
   vec3_type              ctr_ff;
   logic [MUL_W-1:0]      rad_ff;
   logic [15:0]           margin_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [PROD_W-1:0]     sin_ff;
   logic [MUL_W-1:0]      root_ff;
   logic [MUL_W:0]        srem_ff;
   logic [ITER_W-1:0]     iter_ff;
   logic [MUL_W-1:0]      dist_ff;
   logic [MUL_W-1:0]      shift_ff;
   logic                  neg_ff;
   logic [PROD_W-1:0]     dnum_ff;
   logic [MUL_W-1:0]      drem_ff;
   logic [MUL_W-1:0]      dq_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;

   logic [2:0]            lo_sel, hi_sel;
   vec3_type              lo_pt, hi_pt;
   logic signed [COORD_W:0] diff_span, diff_p2;
   logic [COORD_W:0]      mag_span, mag_p2;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [MUL_W-1:0]      lim;
   logic                  outside;
   logic [MUL_W+2:0]      srem_sh, strial;
   logic [MUL_W:0]        drem_sh;
   logic [MUL_W:0]        rad_sum;
   logic signed [COORD_W:0] ctr_step;

   assign lo_sel = {pair_ff, 1'b0};
   assign hi_sel = {pair_ff, 1'b1};
   assign lo_pt = ext_ff[lo_sel];
   assign hi_pt = ext_ff[hi_sel];

   assign diff_span = $signed({lo_pt[k_ff][COORD_W-1], lo_pt[k_ff]})
                    - $signed({hi_pt[k_ff][COORD_W-1], hi_pt[k_ff]});
   assign diff_p2 = $signed({rd_data_ff[k_ff][COORD_W-1], rd_data_ff[k_ff]})
                  - $signed({ctr_ff[k_ff][COORD_W-1], ctr_ff[k_ff]});
   assign mag_span = diff_span[COORD_W] ? (COORD_W+1)'(-diff_span) : diff_span;
   assign mag_p2 = diff_p2[COORD_W] ? (COORD_W+1)'(-diff_p2) : diff_p2;
   assign lim = rad_ff + MUL_W'(margin_ff);
   assign outside = {2'b00, acc_ff} > prod_ff;

   always_comb begin
      case (dp_cmd.op)
         OP_SPAN_SQ: begin
            mul_a = MUL_W'(mag_span);
            mul_b = MUL_W'(mag_span);
         end
         OP_P2_SQ: begin
            mul_a = MUL_W'(mag_p2);
            mul_b = MUL_W'(mag_p2);
         end
         OP_P2_LIM: begin
            mul_a = lim;
            mul_b = lim;
         end
         default: begin
            mul_a = shift_ff;
            mul_b = MUL_W'(mag_p2);
         end
      endcase
   end

   // one root bit per step: bring down two radicand bits, try 4*root+1
   assign srem_sh = {srem_ff, sin_ff[PROD_W-1 -: 2]};
   assign strial = (MUL_W+3)'({root_ff, 2'b01});
   // one quotient bit per step
   assign drem_sh = {drem_ff, dnum_ff[PROD_W-1]};
   assign rad_sum = (MUL_W+1)'(rad_ff) + (MUL_W+1)'(root_ff) + (MUL_W+1)'(1);
   assign ctr_step = neg_ff ? -$signed({1'b0, dq_ff[COORD_W-1:0]})
                            : $signed({1'b0, dq_ff[COORD_W-1:0]});

   always_comb begin
      dp_status.err_ovf = ovf_ff;
      dp_status.err_few = count_ff < CW'(2);
      dp_status.idx_last = CW'(idx_ff) == (count_ff - CW'(1));
      dp_status.k_last = k_ff == 2'd2;
      dp_status.pair_last = pair_ff == 2'd2;
      dp_status.sqrt_last = iter_ff == ITER_W'(SQRT_ITERS - 1);
      dp_status.div_last = iter_ff == ITER_W'(DIV_ITERS - 1);
      dp_status.outside = outside;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_LOAD && count_ff < CW'(MAX_POINTS)) begin
         store_mem[count_ff[AW-1:0]] <= {req_payload.coord_z, req_payload.coord_y,
                                         req_payload.coord_x};
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_READ) begin
         rd_data_ff <= store_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         margin_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ctr_ff <= '0;
         rad_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) margin_ff <= csr_wr_data;
         case (dp_cmd.op)
            OP_LOAD: begin
               if (count_ff < CW'(MAX_POINTS)) count_ff <= count_ff + CW'(1);
               else ovf_ff <= 1'b1;
            end
            OP_ERROR: begin
               rsp_valid_ff <= 1'b1;
               rsp_payload_ff <= {(4*COORD_W)'(0), ovf_ff ? STATUS_OVF : STATUS_FEW};
               count_ff <= '0;
               ovf_ff <= 1'b0;
            end
            OP_INIT_CTR: begin
               for (int a = 0; a < 3; a++) begin
                  ctr_ff[a] <= COORD_W'(($signed({lo_pt[a][COORD_W-1], lo_pt[a]})
                             + $signed({hi_pt[a][COORD_W-1], hi_pt[a]})) >>> 1);
               end
            end
            OP_INIT_RAD: rad_ff <= MUL_W'((MUL_W+1)'(root_ff) + (MUL_W+1)'(1) >> 1);
            OP_P2_RAD: rad_ff <= MUL_W'(rad_sum >> 1);
            OP_P2_UPD: begin
               ctr_ff[k_ff] <= COORD_W'($signed({ctr_ff[k_ff][COORD_W-1], ctr_ff[k_ff]})
                               + ctr_step);
            end
            OP_RESULT: begin
               rsp_valid_ff <= 1'b1;
               rsp_payload_ff.center_x <= ctr_ff[0];
               rsp_payload_ff.center_y <= ctr_ff[1];
               rsp_payload_ff.center_z <= ctr_ff[2];
               // saturate: the radius is kept two bits wider inside
               rsp_payload_ff.sphere_radius <= (|rad_ff[MUL_W-1:COORD_W]) ? '1
                                               : rad_ff[COORD_W-1:0];
               rsp_payload_ff.status <= STATUS_OK;
               count_ff <= '0;
               ovf_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (dp_cmd.op)
         OP_START: begin
            idx_ff <= '0;
            k_ff <= '0;
            pair_ff <= '0;
            acc_ff <= '0;
         end
         OP_P1_UPD: begin
            if (idx_ff == '0) begin
               for (int e = 0; e < 6; e++) ext_ff[e] <= rd_data_ff;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  if ($signed(rd_data_ff[a]) < $signed(ext_ff[2*a][a]))
                     ext_ff[2*a] <= rd_data_ff;
                  if ($signed(rd_data_ff[a]) > $signed(ext_ff[2*a+1][a]))
                     ext_ff[2*a+1] <= rd_data_ff;
               end
            end
            idx_ff <= dp_status.idx_last ? '0 : idx_ff + AW'(1);
         end
         OP_SPAN_SQ, OP_P2_SQ, OP_P2_LIM: prod_ff <= mul_a * mul_b;
         OP_P2_MUL: begin
            prod_ff <= mul_a * mul_b;
            neg_ff <= diff_p2[COORD_W];
         end
         OP_ACC: begin
            acc_ff <= acc_ff + prod_ff[SQ_SUM_W-1:0];
            k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
         end
         OP_SPAN_CMP: begin
            if (pair_ff == 2'd0 || acc_ff > best_ff) begin
               best_ff <= acc_ff;
               best_pair_ff <= pair_ff;
            end
            // after the last pair, point at the winning pair for the centre
            if (pair_ff == 2'd2) pair_ff <= (acc_ff > best_ff) ? pair_ff : best_pair_ff;
            else pair_ff <= pair_ff + 2'd1;
            acc_ff <= '0;
         end
         OP_INIT_CTR: begin
            pair_ff <= best_pair_ff;
            sin_ff <= PROD_W'(best_ff);
            root_ff <= '0;
            srem_ff <= '0;
            iter_ff <= '0;
         end
         OP_SQRT_STEP: begin
            if (srem_sh >= strial) begin
               srem_ff <= (MUL_W+1)'(srem_sh - strial);
               root_ff <= {root_ff[MUL_W-2:0], 1'b1};
            end else begin
               srem_ff <= (MUL_W+1)'(srem_sh);
               root_ff <= {root_ff[MUL_W-2:0], 1'b0};
            end
            sin_ff <= sin_ff << 2;
            iter_ff <= iter_ff + ITER_W'(1);
         end
         OP_INIT_RAD: begin
            idx_ff <= '0;
            k_ff <= '0;
         end
         OP_READ: acc_ff <= '0;
         OP_P2_TEST: begin
            sin_ff <= PROD_W'(acc_ff);
            root_ff <= '0;
            srem_ff <= '0;
            iter_ff <= '0;
         end
         OP_P2_RAD: dist_ff <= root_ff;
         OP_P2_SHIFT: begin
            shift_ff <= dist_ff - rad_ff;
            k_ff <= '0;
         end
         OP_DIV_LOAD: begin
            dnum_ff <= prod_ff;
            drem_ff <= '0;
            dq_ff <= '0;
            iter_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (drem_sh >= (MUL_W+1)'(dist_ff)) begin
               drem_ff <= MUL_W'(drem_sh - (MUL_W+1)'(dist_ff));
               dq_ff <= {dq_ff[MUL_W-2:0], 1'b1};
            end else begin
               drem_ff <= MUL_W'(drem_sh);
               dq_ff <= {dq_ff[MUL_W-2:0], 1'b0};
            end
            dnum_ff <= dnum_ff << 1;
            iter_ff <= iter_ff + ITER_W'(1);
         end
         OP_P2_UPD: k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
         OP_NEXT: idx_ff <= idx_ff + AW'(1);
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/approx_bounding_sphere.sv =====
// Approximate bounding sphere of a 3D point set, two passes over a point store.
// Input: a point is transferred on an edge with start high and busy low. Points
// load one per cycle; the point with last_point set closes the set and raises
// busy until the result is out. Points beyond MAX_POINTS are dropped and the
// set ends with status 2; a set of fewer than two points ends with status 1.
// Output: rsp_valid is high for exactly one cycle with rsp_payload; the receiver
// takes it then and cannot hold it off. busy is low again in that cycle.
// Work after the last point, for N stored points and U outliers, in order:
//   a set check; an extreme pass with one store read and update per point;
//   three spans, squared in sequence on the shared 34x34 multiplier;
//   the initial centre and a 34-step square root;
//   a containment pass (read, three squares, limit, test, advance per point);
//   for each of the U outliers, a square root, then a 68-step divide per axis;
//   then the result state, with the registered strobe after it. The bit-serial root and
//   divider set the outlier cost.
// Error sets pass the set check and the error state, then show a registered strobe.
// Reset clears the point count, the margin register and the controller; the
// store needs no clearing pass.
module approx_bounding_sphere
   import abs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   abs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_point (req_payload.last_point),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .busy       (busy)
   );

   abs_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/abs_checker.sv =====
module abs_checker
   import abs_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input rsp_payload_type rsp_payload
);

   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while result shown");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_payload.last_point))
      else $error("busy without a closing transfer");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |->
         rsp_payload.center_x == '0 && rsp_payload.center_y == '0 &&
         rsp_payload.center_z == '0 && rsp_payload.sphere_radius == '0)
      else $error("error result carries a sphere");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == STATUS_OK || rsp_payload.status == STATUS_FEW
                    || rsp_payload.status == STATUS_OVF)
      else $error("undefined status code");

endmodule

bind approx_bounding_sphere abs_checker u_abs_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
